FILE: rtl/dtd_pkg.sv
// Package for the date to day number and weekday core.
// Holds the word types, the pipeline stage types and the calendar tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtd_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int TOTAL_W = 20;
    localparam int WDAY_W  = 3;
    localparam int QUOT_W  = 6;
    localparam int LEAP_W  = 11;
    localparam int MDAY_W  = 9;

    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int PROD_W       = 25;

    localparam logic [8:0]        DAYS_PER_YEAR = 9'd365;
    localparam logic [6:0]        CENTURY       = 7'd100;
    localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_in_word;

    typedef struct packed {
        logic               valid_res;
        logic [TOTAL_W-1:0] total_days;
        logic [WDAY_W-1:0]  weekday;
    } t_out_word;

    typedef struct packed {
        logic               ok;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [QUOT_W-1:0]  q_year;
        logic [QUOT_W-1:0]  q_prev;
    } t_front;

    typedef struct packed {
        logic ok;
        logic [TOTAL_W-1:0] year_days;
        logic [LEAP_W-1:0]  leap_days;
        logic [MDAY_W-1:0]  month_days;
    } t_mid;

    typedef struct packed {
        logic               ok;
        logic [TOTAL_W-1:0] total;
    } t_sum;

    function automatic logic [MDAY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [MDAY_W-1:0] v;
        case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] v;
        case (m)
            4'd2:                 v = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: v = 5'd30;
            default:              v = 5'd31;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dtd_front.sv
// Front stage: range checks on year and month, and year / 100 quotients
// by reciprocal multiply. Depends on dtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtd_front #(
    parameter int BASE_YEAR = 1900
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_vld,
    input  dtd_pkg::t_in_word i_word,
    output logic              o_vld,
    output dtd_pkg::t_front   o_data
);

    localparam logic [dtd_pkg::YEAR_W-1:0] BASE = dtd_pkg::YEAR_W'(BASE_YEAR);

    logic                          r_vld;
    dtd_pkg::t_front               r_data;
    dtd_pkg::t_front               n_data;
    logic [dtd_pkg::YEAR_W-1:0]    w_prev;
    logic [dtd_pkg::PROD_W-1:0]    w_py;
    logic [dtd_pkg::PROD_W-1:0]    w_pp;

    always_comb begin
        w_prev = i_word.year - dtd_pkg::YEAR_W'(1);
        w_py   = dtd_pkg::PROD_W'(i_word.year) * dtd_pkg::PROD_W'(dtd_pkg::DIV100_MUL);
        w_pp   = dtd_pkg::PROD_W'(w_prev) * dtd_pkg::PROD_W'(dtd_pkg::DIV100_MUL);
        n_data.ok     = (i_word.year >= BASE) && (i_word.month >= dtd_pkg::MONTH_JAN)
                        && (i_word.month <= dtd_pkg::MONTH_DEC);
        n_data.year   = i_word.year;
        n_data.month  = i_word.month;
        n_data.day    = i_word.day;
        n_data.q_year = w_py[dtd_pkg::PROD_W-1:dtd_pkg::DIV100_SHIFT];
        n_data.q_prev = w_pp[dtd_pkg::PROD_W-1:dtd_pkg::DIV100_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_data <= n_data;
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: rtl/dtd_accum.sv
// Middle stages: leap test, day check, year and month day counts, then
// the final day number sum. Depends on dtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtd_accum #(
    parameter int BASE_YEAR = 1900
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_vld,
    input  dtd_pkg::t_front i_data,
    output logic            o_vld,
    output dtd_pkg::t_sum   o_data
);

    localparam int PREV_BASE = BASE_YEAR - 1;
    localparam int LBASE_INT = PREV_BASE / 4 - PREV_BASE / 100 + PREV_BASE / 400;
    localparam logic [dtd_pkg::LEAP_W-1:0]  LBASE = dtd_pkg::LEAP_W'(LBASE_INT);
    localparam logic [dtd_pkg::YEAR_W-1:0]  BASE  = dtd_pkg::YEAR_W'(BASE_YEAR);

    logic                          r_vld2;
    logic                          r_vld3;
    dtd_pkg::t_mid                 r_mid;
    dtd_pkg::t_mid                 n_mid;
    dtd_pkg::t_sum                 r_sum;
    dtd_pkg::t_sum                 n_sum;
    logic                          w_leap;
    logic [dtd_pkg::YEAR_W-1:0]    w_cent;
    logic [dtd_pkg::YEAR_W-1:0]    w_prev;
    logic [dtd_pkg::DAY_W-1:0]     w_mlen;
    logic [dtd_pkg::LEAP_W-1:0]    w_lprev;

    always_comb begin
        w_cent = dtd_pkg::YEAR_W'(i_data.q_year) * dtd_pkg::YEAR_W'(dtd_pkg::CENTURY);
        w_leap = (i_data.year[1:0] == 2'b00)
                 && ((i_data.year != w_cent) || (i_data.q_year[1:0] == 2'b00));
        w_mlen = (i_data.month == dtd_pkg::MONTH_FEB && w_leap) ? dtd_pkg::FEB_LEAP_LEN
                                                                 : dtd_pkg::month_len(i_data.month);
        w_prev  = i_data.year - dtd_pkg::YEAR_W'(1);
        w_lprev = dtd_pkg::LEAP_W'(w_prev[dtd_pkg::YEAR_W-1:2])
                  - dtd_pkg::LEAP_W'(i_data.q_prev)
                  + dtd_pkg::LEAP_W'(i_data.q_prev[dtd_pkg::QUOT_W-1:2]);

        n_mid.ok        = i_data.ok && (i_data.day != '0) && (i_data.day <= w_mlen);
        n_mid.year_days = dtd_pkg::TOTAL_W'(i_data.year - BASE)
                          * dtd_pkg::TOTAL_W'(dtd_pkg::DAYS_PER_YEAR);
        n_mid.leap_days = w_lprev - LBASE;
        n_mid.month_days = dtd_pkg::days_before(i_data.month)
                           + dtd_pkg::MDAY_W'(w_leap && (i_data.month > dtd_pkg::MONTH_FEB))
                           + dtd_pkg::MDAY_W'(i_data.day);
    end

    always_comb begin
        n_sum.ok    = r_mid.ok;
        n_sum.total = r_mid.ok ? (r_mid.year_days + dtd_pkg::TOTAL_W'(r_mid.leap_days)
                                  + dtd_pkg::TOTAL_W'(r_mid.month_days))
                               : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld2 <= i_vld;
            r_vld3 <= r_vld2;
        end
        r_mid <= n_mid;
        r_sum <= n_sum;
    end

    assign o_vld  = r_vld3;
    assign o_data = r_sum;

endmodule

`default_nettype wire

FILE: rtl/dtd_wkday.sv
// Output stage: day number mod 7 by folding octal digits, and the
// result word register. Depends on dtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtd_wkday (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_vld,
    input  dtd_pkg::t_sum      i_data,
    output logic               o_vld,
    output dtd_pkg::t_out_word o_word
);

    localparam int GROUPS = (dtd_pkg::TOTAL_W + 2) / 3;
    localparam int PADDED = GROUPS * 3;

    logic                      r_vld;
    dtd_pkg::t_out_word        r_word;
    dtd_pkg::t_out_word        n_word;
    logic [PADDED-1:0]         w_pad;
    logic [5:0]                w_sum;
    logic [3:0]                w_fold;
    logic [dtd_pkg::WDAY_W-1:0] w_mod;

    always_comb begin
        w_pad = PADDED'(i_data.total);
        w_sum = '0;
        for (int g = 0; g < GROUPS; g++) begin
            w_sum = w_sum + 6'(w_pad[g*3 +: 3]);
        end
        w_fold = 4'(w_sum[5:3]) + 4'(w_sum[2:0]);
        w_mod  = (w_fold >= 4'd7) ? 3'(w_fold - 4'd7) : w_fold[2:0];

        n_word.valid_res  = i_data.ok;
        n_word.total_days = i_data.total;
        n_word.weekday    = i_data.ok ? w_mod : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_word <= n_word;
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule

`default_nettype wire

FILE: rtl/date_to_day_number_weekday_core.sv
// Gregorian date to day number and weekday, four register stages.
// An accepted word passes the dtd_front, dtd_accum and dtd_wkday registers in that order before o_done.
// Throughput: one word per cycle; o_busy stays low, the receiver cannot stall.
// Reset: synchronous, active low; clears the stage valid bits only.
// Depends on dtd_pkg, dtd_front, dtd_accum, dtd_wkday.
`timescale 1ns / 1ps
`default_nettype none

module date_to_day_number_weekday_core #(
    parameter int BASE_YEAR = 1900
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  dtd_pkg::t_in_word  i_word,
    output logic               o_busy,
    output logic               o_done,
    output dtd_pkg::t_out_word o_word
);

    logic            w_acc;
    logic            w_vld1;
    dtd_pkg::t_front w_front;
    logic            w_vld3;
    dtd_pkg::t_sum   w_sum;

    assign o_busy = 1'b0;
    assign w_acc  = i_start && !o_busy;

    dtd_front #(.BASE_YEAR(BASE_YEAR)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_acc),
        .i_word  (i_word),
        .o_vld   (w_vld1),
        .o_data  (w_front)
    );

    dtd_accum #(.BASE_YEAR(BASE_YEAR)) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld1),
        .i_data  (w_front),
        .o_vld   (w_vld3),
        .o_data  (w_sum)
    );

    dtd_wkday u_wkday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld3),
        .i_data  (w_sum),
        .o_vld   (o_done),
        .o_word  (o_word)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##4 o_done)
        else $error("accepted word did not complete in 4 cycles");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_acc, 4))
        else $error("result without an accepted word");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_word.valid_res) |-> (o_word.total_days == '0 && o_word.weekday == '0))
        else $error("invalid date with nonzero fields");

    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_word.valid_res) |-> (o_word.total_days != '0 && o_word.weekday < 3'd7))
        else $error("valid date with out of range fields");

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking bench for date_to_day_number_weekday_core.
// Sends directed and random dates; checks each result in order, listed or predicted.
// Depends on dtd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

    localparam int BASE_YEAR    = 1900;
    localparam int RANDOM_WORDS = 1300;
    localparam int QUIET_TAIL   = 200;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        dtd_pkg::t_in_word  date;
        bit                 typed;
        dtd_pkg::t_out_word result;
    } t_date_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    dtd_pkg::t_in_word  i_word;
    logic               o_busy;
    logic               o_done;
    dtd_pkg::t_out_word o_word;

    bit                 typed_now;
    dtd_pkg::t_out_word typed_word;
    dtd_pkg::t_out_word pending_results[$];
    int                 mismatch_count = 0;
    t_date_row          directed[$];

    date_to_day_number_weekday_core #(.BASE_YEAR(BASE_YEAR)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_word  (i_word),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_word  (o_word)
    );

    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int leaps_upto(input int n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic int month_span(input int y, input int m);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic dtd_pkg::t_out_word day_number(input dtd_pkg::t_in_word w);
        dtd_pkg::t_out_word r;
        int                 y;
        int                 m;
        int                 d;
        int                 total;
        y = int'(w.year);
        m = int'(w.month);
        d = int'(w.day);
        r = '0;
        if (y < BASE_YEAR || m < 1 || m > 12) return r;
        if (d < 1 || d > month_span(y, m)) return r;
        total = (y - BASE_YEAR) * 365 + leaps_upto(y - 1) - leaps_upto(BASE_YEAR - 1);
        for (int k = 1; k < m; k++) total += month_span(y, k);
        total += d;
        r.valid_res  = 1'b1;
        r.total_days = dtd_pkg::TOTAL_W'(total);
        r.weekday    = dtd_pkg::WDAY_W'(total % 7);
        return r;
    endfunction

    function automatic t_date_row date_row(input int y, input int m, input int d,
                                           input bit typed = 1'b0, input bit v = 1'b0,
                                           input int total = 0, input int wd = 0);
        t_date_row row;
        row.date.year         = dtd_pkg::YEAR_W'(y);
        row.date.month        = dtd_pkg::MONTH_W'(m);
        row.date.day          = dtd_pkg::DAY_W'(d);
        row.typed             = typed;
        row.result.valid_res  = v;
        row.result.total_days = dtd_pkg::TOTAL_W'(total);
        row.result.weekday    = dtd_pkg::WDAY_W'(wd);
        return row;
    endfunction

    // Enter and leave at a falling edge.
    task automatic send_date(input dtd_pkg::t_in_word w, input bit typed,
                             input dtd_pkg::t_out_word r, input bit gaps);
        int idle;
        if (gaps && $urandom_range(3) == 0) begin
            idle = $urandom_range(10, 1);
            i_start <= 1'b0;
            repeat (idle) begin
                i_word <= ($bits(dtd_pkg::t_in_word))'($urandom);
                @(negedge i_clk);
            end
        end
        i_start    <= 1'b1;
        i_word     <= w;
        typed_now  <= typed;
        typed_word <= r;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin : check_results
        dtd_pkg::t_out_word want;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result word, actual v=%0d days=%0d wd=%0d",
                             $time, o_word.valid_res, o_word.total_days, o_word.weekday);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_word.valid_res !== want.valid_res ||
                        o_word.total_days !== want.total_days ||
                        o_word.weekday !== want.weekday) begin
                        $display("%0t: expected v=%0d days=%0d wd=%0d, actual v=%0d days=%0d wd=%0d",
                                 $time, want.valid_res, want.total_days, want.weekday,
                                 o_word.valid_res, o_word.total_days, o_word.weekday);
                        mismatch_count++;
                    end
                end
            end
            if (i_start && !o_busy)
                pending_results.push_back(typed_now ? typed_word : day_number(i_word));
        end
    end

    initial begin : stimulus
        dtd_pkg::t_in_word  w;
        dtd_pkg::t_out_word none;
        int                 span;
        int                 waited;
        none       = '0;
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_word     = '0;
        typed_now  = 1'b0;
        typed_word = '0;

        directed.push_back(date_row(1900, 1, 1, 1'b1, 1'b1, 1, 1));
        directed.push_back(date_row(4095, 12, 31, 1'b1, 1'b1, 802073, 6));
        directed.push_back(date_row(1899, 12, 31, 1'b1));
        directed.push_back(date_row(0, 0, 0, 1'b1));
        directed.push_back(date_row(2000, 0, 15, 1'b1));
        directed.push_back(date_row(2000, 13, 1, 1'b1));
        directed.push_back(date_row(2000, 15, 31, 1'b1));
        directed.push_back(date_row(2000, 1, 0, 1'b1));
        directed.push_back(date_row(2001, 2, 29, 1'b1));
        directed.push_back(date_row(1900, 2, 29, 1'b1));
        directed.push_back(date_row(4095, 2, 29, 1'b1));
        directed.push_back(date_row(2000, 4, 31, 1'b1));
        directed.push_back(date_row(2023, 11, 31, 1'b1));
        directed.push_back(date_row(2000, 2, 29));
        directed.push_back(date_row(2004, 2, 29));
        directed.push_back(date_row(4092, 2, 29));
        directed.push_back(date_row(2000, 1, 31));
        directed.push_back(date_row(2000, 3, 1));
        directed.push_back(date_row(1900, 3, 1));
        directed.push_back(date_row(1900, 12, 31));
        directed.push_back(date_row(2100, 2, 28));
        directed.push_back(date_row(2400, 12, 31));
        directed.push_back(date_row(4095, 1, 31));
        directed.push_back(date_row(2023, 11, 30));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[k])
            send_date(directed[k].date, directed[k].typed, directed[k].result, 1'b1);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if ($urandom_range(4) == 0) begin
                w = ($bits(dtd_pkg::t_in_word))'($urandom);
            end else begin
                if ($urandom_range(3) == 0)
                    w.year = dtd_pkg::YEAR_W'($urandom_range(40, 19) * 100);
                else
                    w.year = dtd_pkg::YEAR_W'($urandom_range(4095, BASE_YEAR));
                w.month = dtd_pkg::MONTH_W'($urandom_range(12, 1));
                span    = month_span(int'(w.year), int'(w.month));
                case ($urandom_range(9))
                    0:       w.day = dtd_pkg::DAY_W'(span + 1);
                    1, 2, 3: w.day = dtd_pkg::DAY_W'(span);
                    default: w.day = dtd_pkg::DAY_W'($urandom_range(span, 1));
                endcase
            end
            send_date(w, 1'b0, none, n < RANDOM_WORDS - QUIET_TAIL);
        end

        i_start <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
